// ----- rtl/clt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the command line tokenizer.
// No dependencies; used by every other file of the block.
package clt_pkg;

    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = 2;
    localparam int QUEUE_DEPTH = 4;
    // output tdata carries only the value; the kind travels on tuser
    localparam int OUT_DATA_W  = 8;

    // result kinds
    localparam logic [KIND_W-1:0] K_CMD_CHAR   = 3'd0;
    localparam logic [KIND_W-1:0] K_ARG_CHAR   = 3'd1;
    localparam logic [KIND_W-1:0] K_CMD_END    = 3'd2;
    localparam logic [KIND_W-1:0] K_ARG_END    = 3'd3;
    localparam logic [KIND_W-1:0] K_BAD_PREFIX = 3'd4;
    localparam logic [KIND_W-1:0] K_BAD_CMD    = 3'd5;
    localparam logic [KIND_W-1:0] K_LINE_DONE  = 3'd6;

    // special bytes
    localparam logic [CHAR_W-1:0] C_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] C_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] C_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] C_BSLASH = 8'h5c;
    localparam logic [CHAR_W-1:0] C_CR     = 8'h0d;
    localparam logic [CHAR_W-1:0] C_LF     = 8'h0a;
    localparam logic [CHAR_W-1:0] C_DASH   = 8'h2d;

    typedef struct packed {
        logic [CHAR_W-1:0] value;
        logic [KIND_W-1:0] kind;
    } clt_result_t;

    // all results caused by one input item; count is 1..3
    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        clt_result_t [MAX_RESULTS-1:0]     res;
    } clt_bundle_t;

endpackage

// ----- rtl/clt_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the line state and classifies each
// byte into a bundle of up to three results. Depends on clt_pkg.
module clt_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          prefix_we,
    input  logic [clt_pkg::CHAR_W-1:0]    prefix_wdata,
    input  logic                          in_valid,
    input  logic [clt_pkg::CHAR_W-1:0]    in_ch,
    input  logic                          in_eol,
    output logic                          in_ready,
    input  logic                          q_full,
    output logic                          push,
    output clt_pkg::clt_bundle_t          push_data
);

    typedef enum logic [1:0] {
        MODE_START,
        MODE_COMMAND,
        MODE_ARGUMENT,
        MODE_SWALLOW
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic                          esc_reg, esc_next;
    logic                          inq_reg, inq_next;
    logic                          dq_reg, dq_next;
    logic                          tok_reg, tok_next;
    logic [clt_pkg::CHAR_W-1:0]    prefix_reg;
    logic                          accept;

    function automatic logic is_cmd_char(input logic [clt_pkg::CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == clt_pkg::C_DASH);
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [clt_pkg::COUNT_W-1:0]           n;
        clt_pkg::clt_result_t [clt_pkg::MAX_RESULTS-1:0] res;
        logic                                  do_cmd;
        logic                                  is_dq;

        n         = '0;
        res       = '0;
        do_cmd    = 1'b0;
        is_dq     = (in_ch == clt_pkg::C_DQUOTE);
        mode_next = mode_reg;
        esc_next  = esc_reg;
        inq_next  = inq_reg;
        dq_next   = dq_reg;
        tok_next  = tok_reg;

        unique case (mode_reg)
            MODE_START:
            begin
                if (prefix_reg == '0)
                begin
                    mode_next = MODE_COMMAND;
                    do_cmd    = 1'b1;
                end
                else if (in_ch == prefix_reg)
                begin
                    mode_next = MODE_COMMAND;
                end
                else
                begin
                    mode_next    = MODE_SWALLOW;
                    res[n].kind  = clt_pkg::K_BAD_PREFIX;
                    res[n].value = in_ch;
                    n            = n + 2'd1;
                end
            end
            MODE_COMMAND:
            begin
                do_cmd = 1'b1;
            end
            MODE_ARGUMENT:
            begin
                if (esc_reg)
                begin
                    esc_next     = 1'b0;
                    tok_next     = 1'b1;
                    res[n].kind  = clt_pkg::K_ARG_CHAR;
                    res[n].value = in_ch;
                    n            = n + 2'd1;
                end
                else if (in_ch == clt_pkg::C_BSLASH)
                begin
                    esc_next = 1'b1;
                end
                else if (in_ch == clt_pkg::C_SQUOTE || in_ch == clt_pkg::C_DQUOTE)
                begin
                    if (!inq_reg)
                    begin
                        inq_next = 1'b1;
                        dq_next  = is_dq;
                    end
                    else if (dq_reg == is_dq)
                    begin
                        inq_next = 1'b0;
                    end
                    else
                    begin
                        // quote of the other kind is plain text
                        tok_next     = 1'b1;
                        res[n].kind  = clt_pkg::K_ARG_CHAR;
                        res[n].value = in_ch;
                        n            = n + 2'd1;
                    end
                end
                else if (!inq_reg && in_ch == clt_pkg::C_CR)
                begin
                end
                else if (!inq_reg && (in_ch == clt_pkg::C_SPACE || in_ch == clt_pkg::C_LF))
                begin
                    tok_next    = 1'b0;
                    res[n].kind = clt_pkg::K_ARG_END;
                    n           = n + 2'd1;
                end
                else
                begin
                    tok_next     = 1'b1;
                    res[n].kind  = clt_pkg::K_ARG_CHAR;
                    res[n].value = in_ch;
                    n            = n + 2'd1;
                end
            end
            MODE_SWALLOW:
            begin
            end
            default:
            begin
            end
        endcase

        if (do_cmd)
        begin
            if (is_cmd_char(in_ch))
            begin
                tok_next     = 1'b1;
                res[n].kind  = clt_pkg::K_CMD_CHAR;
                res[n].value = in_ch;
                n            = n + 2'd1;
            end
            else if (in_ch == clt_pkg::C_SPACE)
            begin
                mode_next   = MODE_ARGUMENT;
                tok_next    = 1'b0;
                res[n].kind = clt_pkg::K_CMD_END;
                n           = n + 2'd1;
            end
            else if (in_ch == clt_pkg::C_CR || in_ch == clt_pkg::C_LF)
            begin
            end
            else
            begin
                mode_next    = MODE_SWALLOW;
                res[n].kind  = clt_pkg::K_BAD_CMD;
                res[n].value = in_ch;
                n            = n + 2'd1;
            end
        end

        if (in_eol)
        begin
            // close an open token, then report the line end
            if (tok_next && mode_next == MODE_COMMAND)
            begin
                res[n].kind = clt_pkg::K_CMD_END;
                n           = n + 2'd1;
            end
            else if (tok_next && mode_next == MODE_ARGUMENT)
            begin
                res[n].kind = clt_pkg::K_ARG_END;
                n           = n + 2'd1;
            end
            res[n].kind = clt_pkg::K_LINE_DONE;
            n           = n + 2'd1;
            mode_next   = MODE_START;
            esc_next    = 1'b0;
            inq_next    = 1'b0;
            dq_next     = 1'b0;
            tok_next    = 1'b0;
        end

        push_data.count = n;
        push_data.res   = res;
        push            = accept && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            esc_reg    <= 1'b0;
            inq_reg    <= 1'b0;
            dq_reg     <= 1'b0;
            tok_reg    <= 1'b0;
            prefix_reg <= '0;
        end
        else
        begin
            if (prefix_we)
            begin
                prefix_reg <= prefix_wdata;
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                inq_reg  <= inq_next;
                dq_reg   <= dq_next;
                tok_reg  <= tok_next;
            end
        end
    end

endmodule

// ----- rtl/clt_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of result bundles between the front and back ends.
// Depends on clt_pkg. DEPTH must be a power of two.
module clt_queue
#(
    parameter int DEPTH = clt_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  clt_pkg::clt_bundle_t    push_data,
    input  logic                    pop,
    output clt_pkg::clt_bundle_t    head,
    output logic                    empty,
    output logic                    full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clt_pkg::clt_bundle_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/clt_back.sv -----
`timescale 1ns / 1ps
// Back end: unpacks queued bundles into single result items, one per cycle
// unless the output stalls, into a registered output stage. Depends on clt_pkg.
module clt_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  clt_pkg::clt_bundle_t              head,
    input  logic                              empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [clt_pkg::OUT_DATA_W-1:0]    out_data,
    output logic [clt_pkg::KIND_W-1:0]        out_user,
    output logic                              out_last
);

    logic [clt_pkg::COUNT_W-1:0]          idx_reg;
    logic                                 valid_reg;
    logic [clt_pkg::OUT_DATA_W-1:0]       data_reg;
    logic [clt_pkg::KIND_W-1:0]           user_reg;
    logic                                 last_reg;
    logic                                 load;
    logic                                 at_end;
    clt_pkg::clt_result_t                 sel;

    assign load   = !empty && (!valid_reg || out_ready);
    assign sel    = head.res[idx_reg];
    assign at_end = (idx_reg == head.count - 2'd1);
    assign pop    = load && at_end;

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= sel.value;
            user_reg <= sel.kind;
            last_reg <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? '0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/command_line_tokenizer.sv -----
`timescale 1ns / 1ps
// Command line tokenizer, top level.
// Input stream: one byte per item on s_tdata[7:0], s_tlast marks the last
// byte of a line. Output stream: one result per item, m_tuser[2:0] kind,
// m_tdata[7:0] value, m_tlast set on the last result caused by one byte.
// prefix_we/prefix_wdata write the required first byte of a line (zero: no
// prefix); write it only while the block is idle.
// A byte's results pass through the bundle queue, then the registered output
// stage. The input takes one byte per cycle while the queue is not full;
// bytes without results cost no output slot, and each result takes its own
// slot; the bundle queue (QUEUE_DEPTH bundles) absorbs a line-final byte
// with three results, and s_tready drops only when the queue fills.
// When the receiver stalls, the output register holds its item and the
// queue fills, then s_tready goes low. Reset empties the queue, clears the
// output and returns to line start with prefix zero.
module command_line_tokenizer
#(
    parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              prefix_we,
    input  logic [clt_pkg::CHAR_W-1:0]        prefix_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // [7:0] ch
    input  logic                              s_tlast,    // end_of_line
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [clt_pkg::OUT_DATA_W-1:0]    m_tdata,    // [7:0] value
    output logic [clt_pkg::KIND_W-1:0]        m_tuser,    // [2:0] kind
    output logic                              m_tlast     // last_of_run
);

    logic                    push, pop, q_empty, q_full;
    clt_pkg::clt_bundle_t    push_data, head;

    clt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .prefix_we    (prefix_we),
        .prefix_wdata (prefix_wdata),
        .in_valid     (s_tvalid),
        .in_ch        (s_tdata),
        .in_eol       (s_tlast),
        .in_ready     (s_tready),
        .q_full       (q_full),
        .push         (push),
        .push_data    (push_data)
    );

    clt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    clt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ----- rtl/clt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the command line tokenizer, bound to the top level.
// Depends on clt_pkg.
module clt_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [clt_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [clt_pkg::KIND_W-1:0]        m_tuser,
    input  logic                              m_tlast
);

    // stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("output item changed while stalled");

    // line done always closes the run of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == clt_pkg::K_LINE_DONE |-> m_tlast)
        else $error("line done without tlast");

    // end markers carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == clt_pkg::K_CMD_END || m_tuser == clt_pkg::K_ARG_END ||
        m_tuser == clt_pkg::K_LINE_DONE) |-> m_tdata == 8'd0)
        else $error("end marker with nonzero value");

    // only defined kinds leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= clt_pkg::K_LINE_DONE)
        else $error("undefined result kind");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
